### rtl/ctr_pkg.sv
package ctr_pkg;

  // Width of a per-slot byte count (holds the largest capacity itself)
  localparam int COUNT_W = 7;
  localparam int CHUNK_W = COUNT_W - 3;

  // Register indexes, taken from paddr[4:2]
  localparam logic [2:0] REG_SUB_COUNT = 3'd0;
  localparam logic [2:0] REG_SUB_ID0   = 3'd1;
  localparam logic [2:0] REG_SUB_ID1   = 3'd2;
  localparam logic [2:0] REG_SUB_ID2   = 3'd3;
  localparam logic [2:0] REG_SUB_ID3   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_WR_LO,
    ST_WR_HI,
    ST_DLV_RD,
    ST_DLV_LD
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               toggle;
    logic               started;
    logic               overflow;
  } slot_ctl_t;

endpackage

### rtl/can_transfer_reassembler.sv
// CAN multi-frame transfer reassembler.
// Input channel (in_valid/in_stall): one CAN frame per transfer, with can_id,
// frame_len and frame_data. Output channel (out_valid/out_stall): one
// 8-byte chunk per transfer; a completed message leaves as one to eight
// chunks, the last marked by last_chunk. Subscriptions are set through the
// APB port (count at 0x00, slot ids at 0x04..0x10); the user must do so only
// while the block is idle, which the block does not enforce. Slot control
// words and message bytes live in two memories with registered reads; each
// frame that passes the checks is a read, modify and write back of its slot.
// A frame is taken only in idle, then goes through the plan step and two
// word writes into the byte memory, done in turn for its single write port;
// a frame that ends a message adds a word read and an output load per chunk.
// Empty or unsubscribed frames are taken without leaving idle; frames that
// are out of sequence or carry the wrong toggle leave after the plan step.
// Reset clears the configuration, the slot control valid bits and the output
// valid bit; no clearing pass is needed. While out_stall is high the chunk
// held at the output stays put and delivery of further chunks waits.
module can_transfer_reassembler
  import ctr_pkg::*;
#(
  parameter int NUM_SLOTS         = 4,
  parameter int MAX_MESSAGE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // frame input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [28:0] can_id,
  input  logic [3:0]  frame_len,
  input  logic [63:0] frame_data,
  // chunk output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] message_id,
  output logic [1:0]  slot_index,
  output logic [63:0] chunk_data,
  output logic [3:0]  chunk_bytes,
  output logic [6:0]  total_length,
  output logic        overflowed,
  output logic        last_chunk,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WORDS  = (MAX_MESSAGE_BYTES + 7) / 8;
  localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_MESSAGE_BYTES);

  // configuration registers
  logic [2:0]  sub_count;
  logic [15:0] sub_id [4];
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_count <= '0;
      for (int i = 0; i < 4; i++) sub_id[i] <= '0;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_SUB_COUNT: sub_count <= pwdata[2:0];
        REG_SUB_ID0:   sub_id[0] <= pwdata[15:0];
        REG_SUB_ID1:   sub_id[1] <= pwdata[15:0];
        REG_SUB_ID2:   sub_id[2] <= pwdata[15:0];
        REG_SUB_ID3:   sub_id[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SUB_COUNT: prdata = {29'd0, sub_count};
      REG_SUB_ID0:   prdata = {16'd0, sub_id[0]};
      REG_SUB_ID1:   prdata = {16'd0, sub_id[1]};
      REG_SUB_ID2:   prdata = {16'd0, sub_id[2]};
      REG_SUB_ID3:   prdata = {16'd0, sub_id[3]};
      default:       prdata = '0;
    endcase
  end

  // state and frame registers
  state_t state, state_next;

  logic [15:0]        f_id;
  logic [SLOT_W-1:0]  f_slot;
  logic [3:0]         f_len;
  logic [63:0]        f_data;

  logic [127:0]       pl_data;
  logic [15:0]        pl_be;
  logic [CHUNK_W-1:0] pl_word;
  slot_ctl_t          pl_ctl;
  logic               pl_deliver;

  logic [CHUNK_W-1:0] chunk_k;

  // subscription match, lowest slot wins
  logic              hit_found;
  logic [SLOT_W-1:0] hit_slot;
  logic              in_accept;

  assign in_accept = in_valid && !in_stall;

  always_comb begin
    hit_found = 1'b0;
    hit_slot  = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (3'(s) < sub_count && sub_id[s] == can_id[23:8]) begin
        hit_found = 1'b1;
        hit_slot  = SLOT_W'(s);
      end
    end
  end

  // slot control memory, valid bits stand in for its reset
  slot_ctl_t                ctl_mem [1 << SLOT_W];
  logic [(1 << SLOT_W)-1:0] slot_valid;
  slot_ctl_t                ctl_rdata;
  logic                     ctl_rvalid;
  logic                     ctl_we;
  slot_ctl_t                ctl_wdata;

  always_ff @(posedge clk) begin
    if (ctl_we) ctl_mem[f_slot] <= ctl_wdata;
    ctl_rdata  <= ctl_mem[hit_slot];
    ctl_rvalid <= slot_valid[hit_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (ctl_we) begin
      slot_valid[f_slot] <= 1'b1;
    end
  end

  // message byte memory, one 64-bit word per chunk with byte enables
  logic [63:0]              msg_mem [1 << (SLOT_W + WORD_W)];
  logic                     mem_we;
  logic [SLOT_W+WORD_W-1:0] mem_waddr;
  logic [63:0]              mem_wdata;
  logic [7:0]               mem_be;
  logic [SLOT_W+WORD_W-1:0] rd_addr;
  logic [63:0]              mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int b = 0; b < 8; b++) begin
        if (mem_be[b]) msg_mem[mem_waddr][8*b +: 8] <= mem_wdata[8*b +: 8];
      end
    end
    mem_rdata <= msg_mem[rd_addr];
  end

  assign rd_addr = {f_slot, chunk_k[WORD_W-1:0]};

  // frame decode and append plan
  slot_ctl_t          cur;
  logic [7:0]         tail;
  logic               t_st, t_en, t_tg;
  logic               plan_ok, plan_deliver, first_two, ovf_base;
  logic [COUNT_W-1:0] base, room, new_count;
  logic [2:0]         n_bytes, w_bytes;
  logic               ovf_new;
  logic [63:0]        payload;
  logic [127:0]       wide;
  logic [15:0]        be16;
  slot_ctl_t          new_ctl;

  always_comb begin
    cur          = ctl_rvalid ? ctl_rdata : '0;
    tail         = 8'(f_data >> {3'(f_len - 4'd1), 3'b000});
    t_st         = tail[7];
    t_en         = tail[6];
    t_tg         = tail[5];
    plan_ok      = 1'b0;
    plan_deliver = 1'b0;
    first_two    = 1'b0;
    ovf_base     = cur.overflow;
    base         = cur.count;
    n_bytes      = 3'(f_len - 4'd1);
    new_ctl      = cur;
    priority if (t_st && t_en && !t_tg) begin
      // single-frame message: restart the slot and deliver at once
      plan_ok      = 1'b1;
      plan_deliver = 1'b1;
      base         = '0;
      ovf_base     = 1'b0;
    end else if (t_tg != cur.toggle) begin
      plan_ok = 1'b0;
    end else if (!cur.started) begin
      if (t_st) begin
        plan_ok         = 1'b1;
        first_two       = 1'b1;
        n_bytes         = (f_len >= 4'd3) ? 3'(f_len - 4'd3) : 3'd0;
        new_ctl.started = 1'b1;
        new_ctl.toggle  = !cur.toggle;
      end
    end else if (!t_st) begin
      plan_ok      = 1'b1;
      plan_deliver = t_en;
      if (!t_en) new_ctl.toggle = !cur.toggle;
    end

    room      = MAX_COUNT - base;
    ovf_new   = ovf_base || ({4'd0, n_bytes} > room);
    w_bytes   = ({4'd0, n_bytes} > room) ? room[2:0] : n_bytes;
    new_count = base + COUNT_W'(w_bytes);
    payload   = first_two ? (f_data >> 16) : f_data;
    wide      = {64'd0, payload} << {base[2:0], 3'b000};
    be16      = ((16'd1 << w_bytes) - 16'd1) << base[2:0];
    new_ctl.count    = new_count;
    new_ctl.overflow = ovf_new;
  end

  // chunk assembly
  logic [COUNT_W-1:0] rem;
  logic [3:0]         nb;
  logic               last;
  logic [63:0]        masked;
  logic               out_free;
  logic               chunk_load;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    rem  = pl_ctl.count - {chunk_k, 3'b000};
    nb   = (rem > COUNT_W'(8)) ? 4'd8 : rem[3:0];
    last = (rem <= COUNT_W'(8));
    for (int b = 0; b < 8; b++) begin
      masked[8*b +: 8] = (4'(b) < nb) ? mem_rdata[8*b +: 8] : 8'd0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && frame_len != 4'd0 && hit_found) state_next = ST_PLAN;
      end
      ST_PLAN:   state_next = plan_ok ? ST_WR_LO : ST_IDLE;
      ST_WR_LO:  state_next = ST_WR_HI;
      ST_WR_HI:  state_next = pl_deliver ? ST_DLV_RD : ST_IDLE;
      ST_DLV_RD: state_next = ST_DLV_LD;
      ST_DLV_LD: begin
        if (out_free) state_next = last ? ST_IDLE : ST_DLV_RD;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = {f_slot, pl_word[WORD_W-1:0]};
    mem_wdata  = pl_data[63:0];
    mem_be     = pl_be[7:0];
    ctl_we     = 1'b0;
    ctl_wdata  = pl_ctl;
    chunk_load = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_PLAN:  ;
      ST_WR_LO: mem_we = 1'b1;
      ST_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = {f_slot, WORD_W'(pl_word[WORD_W-1:0] + WORD_W'(1))};
        mem_wdata = pl_data[127:64];
        mem_be    = pl_be[15:8];
        ctl_we    = !pl_deliver;
      end
      ST_DLV_RD: ;
      ST_DLV_LD: begin
        chunk_load = out_free;
        // clear the slot once the final chunk goes out
        ctl_we     = out_free && last;
        ctl_wdata  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      f_id   <= can_id[23:8];
      f_slot <= hit_slot;
      f_len  <= (frame_len > 4'd8) ? 4'd8 : frame_len;
      f_data <= frame_data;
    end
    if (state == ST_PLAN) begin
      pl_data    <= wide;
      pl_be      <= be16;
      pl_word    <= base[COUNT_W-1:3];
      pl_ctl     <= new_ctl;
      pl_deliver <= plan_deliver;
    end
    if (state == ST_PLAN)  chunk_k <= '0;
    else if (chunk_load)   chunk_k <= chunk_k + CHUNK_W'(1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chunk_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chunk_load) begin
      message_id   <= f_id;
      slot_index   <= 2'(f_slot);
      chunk_data   <= masked;
      chunk_bytes  <= nb;
      total_length <= pl_ctl.count;
      overflowed   <= pl_ctl.overflow;
      last_chunk   <= last;
    end
  end

  // never overwrite a chunk the receiver is stalling on
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    chunk_load |-> !(out_valid && out_stall))
    else $error("chunk loaded over a stalled transfer");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (chunk_load && last) |=> state == ST_IDLE)
    else $error("delivery did not end after the final chunk");

  a_write_pair: assert property (@(posedge clk) disable iff (rst)
    state == ST_WR_HI |-> $past(state) == ST_WR_LO)
    else $error("upper word write without lower word write");

endmodule

### verif/can_transfer_reassembler_test.sv
`timescale 1ns / 1ps

module can_transfer_reassembler_test
  import ctr_pkg::*;
();

  localparam int SLOTS        = 4;
  localparam int MSG_CAPACITY = 64;

  typedef struct packed {
    logic [28:0] can_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic        drain_first;
  } frame_t;

  typedef struct packed {
    logic [15:0] message_id;
    logic [1:0]  slot_index;
    logic [63:0] chunk_data;
    logic [3:0]  chunk_bytes;
    logic [6:0]  total_length;
    logic        overflowed;
    logic        last_chunk;
  } chunk_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [28:0] can_id = '0;
  logic [3:0]  frame_len = '0;
  logic [63:0] frame_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] message_id;
  logic [1:0]  slot_index;
  logic [63:0] chunk_data;
  logic [3:0]  chunk_bytes;
  logic [6:0]  total_length;
  logic        overflowed;
  logic        last_chunk;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  can_transfer_reassembler #(
    .NUM_SLOTS        (SLOTS),
    .MAX_MESSAGE_BYTES(MSG_CAPACITY)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .can_id      (can_id),
    .frame_len   (frame_len),
    .frame_data  (frame_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .message_id  (message_id),
    .slot_index  (slot_index),
    .chunk_data  (chunk_data),
    .chunk_bytes (chunk_bytes),
    .total_length(total_length),
    .overflowed  (overflowed),
    .last_chunk  (last_chunk),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk = ~clk;

  // Subscription settings as the block should hold them
  logic [2:0]  cfg_count = '0;
  logic [15:0] cfg_id [SLOTS];

  // Per-slot assembly state
  logic [7:0]  slot_bytes [SLOTS][MSG_CAPACITY];
  int          slot_fill [SLOTS];
  bit          slot_toggle [SLOTS];
  bit          slot_started [SLOTS];
  bit          slot_overflow [SLOTS];

  frame_t      frame_q [$];
  chunk_t      chunk_expect_q [$];
  frame_t      staged_a [$];
  frame_t      staged_b [$];

  int          frames_pending = 0;
  int          frames_accepted = 0;
  int          chunks_checked = 0;
  int          messages_seen = 0;
  int          overflow_messages = 0;
  int          mismatch_count = 0;

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      cfg_id[s] = '0;
      slot_fill[s] = 0;
      slot_toggle[s] = 0;
      slot_started[s] = 0;
      slot_overflow[s] = 0;
    end
  end

  task automatic clear_assembly(input int slot);
    slot_fill[slot] = 0;
    slot_toggle[slot] = 0;
    slot_started[slot] = 0;
    slot_overflow[slot] = 0;
  endtask

  task automatic append_bytes(input int slot, input logic [63:0] data, input int first,
                              input int n);
    int k;
    for (k = 0; k < n; k++) begin
      if (slot_fill[slot] < MSG_CAPACITY) begin
        slot_bytes[slot][slot_fill[slot]] = data[8*(first+k) +: 8];
        slot_fill[slot] = slot_fill[slot] + 1;
      end else begin
        slot_overflow[slot] = 1;
      end
    end
  endtask

  task automatic deliver_chunks(input int slot, input logic [15:0] mid);
    int     total;
    int     chunks;
    int     k;
    int     b;
    chunk_t c;
    total = slot_fill[slot];
    chunks = (total + 7) / 8;
    if (chunks == 0) chunks = 1;
    for (k = 0; k < chunks; k++) begin
      c.message_id = mid;
      c.slot_index = 2'(slot);
      c.chunk_data = '0;
      c.chunk_bytes = '0;
      for (b = 0; b < 8; b++) begin
        if (k*8 + b < total) begin
          c.chunk_data[8*b +: 8] = slot_bytes[slot][k*8 + b];
          c.chunk_bytes = c.chunk_bytes + 4'd1;
        end
      end
      c.total_length = 7'(total);
      c.overflowed = slot_overflow[slot];
      c.last_chunk = (k == chunks - 1);
      chunk_expect_q.push_back(c);
    end
  endtask

  // Work out the chunks one accepted frame releases
  task automatic reassemble_frame(input logic [28:0] cid, input logic [3:0] flen,
                                  input logic [63:0] data);
    logic [15:0] mid;
    int          len;
    int          active;
    int          slot;
    int          s;
    bit          found;
    bit          sof;
    bit          eof;
    bit          tog;
    mid = cid[23:8];
    len = (flen > 8) ? 8 : flen;
    active = (cfg_count > SLOTS) ? SLOTS : cfg_count;
    found = 0;
    slot = 0;
    for (s = 0; s < active; s++) begin
      if (!found && cfg_id[s] == mid) begin
        slot = s;
        found = 1;
      end
    end
    if (len != 0 && found) begin
      sof = data[8*len-1];
      eof = data[8*len-2];
      tog = data[8*len-3];
      if (sof && eof && !tog) begin
        // single-frame message: abort whatever was in progress
        clear_assembly(slot);
        append_bytes(slot, data, 0, len - 1);
        deliver_chunks(slot, mid);
        clear_assembly(slot);
      end else if (tog == slot_toggle[slot]) begin
        if (!slot_started[slot]) begin
          if (sof) begin
            slot_started[slot] = 1;
            slot_toggle[slot] = !slot_toggle[slot];
            // skip the two CRC bytes
            if (len >= 3) append_bytes(slot, data, 2, len - 3);
          end
        end else if (!sof) begin
          append_bytes(slot, data, 0, len - 1);
          if (!eof) begin
            slot_toggle[slot] = !slot_toggle[slot];
          end else begin
            deliver_chunks(slot, mid);
            clear_assembly(slot);
          end
        end
      end
    end
  endtask

  // Frame driver
  int     send_gap = 0;
  bit     send_burst = 0;
  frame_t next_frame;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        reassemble_frame(can_id, frame_len, frame_data);
        frames_pending--;
        frames_accepted++;
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 6);
      end
      if (frame_q.size() != 0) next_frame = frame_q[0];
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (frame_q.size() != 0 &&
                   !(next_frame.drain_first && chunk_expect_q.size() != 0)) begin
        next_frame = frame_q.pop_front();
        in_valid <= 1'b1;
        can_id <= next_frame.can_id;
        frame_len <= next_frame.frame_len;
        frame_data <= next_frame.frame_data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Chunk monitor
  int     recv_wait = 0;
  bit     recv_burst = 0;
  chunk_t got_chunk;
  chunk_t want_chunk;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_chunk = {message_id, slot_index, chunk_data, chunk_bytes, total_length,
                     overflowed, last_chunk};
        chunks_checked++;
        if (last_chunk) begin
          messages_seen++;
          if (overflowed) overflow_messages++;
        end
        if (chunk_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected chunk: id=%h slot=%0d data=%h bytes=%0d len=%0d ovf=%b last=%b",
                     message_id, slot_index, chunk_data, chunk_bytes, total_length,
                     overflowed, last_chunk);
        end else begin
          want_chunk = chunk_expect_q.pop_front();
          if (got_chunk !== want_chunk) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("chunk %0d exp: id=%h slot=%0d data=%h bytes=%0d len=%0d ovf=%b last=%b",
                       chunks_checked, want_chunk.message_id, want_chunk.slot_index,
                       want_chunk.chunk_data, want_chunk.chunk_bytes, want_chunk.total_length,
                       want_chunk.overflowed, want_chunk.last_chunk);
              $display("chunk %0d got: id=%h slot=%0d data=%h bytes=%0d len=%0d ovf=%b last=%b",
                       chunks_checked, message_id, slot_index, chunk_data, chunk_bytes,
                       total_length, overflowed, last_chunk);
            end
          end
        end
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 6);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait > 0);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SUB_COUNT: cfg_count = value[2:0];
      REG_SUB_ID0, REG_SUB_ID1, REG_SUB_ID2, REG_SUB_ID3:
        cfg_id[2'(idx - REG_SUB_ID0)] = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_subscriptions(input logic [2:0] count, input logic [15:0] id0,
                                   input logic [15:0] id1, input logic [15:0] id2,
                                   input logic [15:0] id3);
    write_reg(REG_SUB_ID0, ($urandom << 16) | id0);
    write_reg(REG_SUB_ID1, ($urandom << 16) | id1);
    write_reg(REG_SUB_ID2, ($urandom << 16) | id2);
    write_reg(REG_SUB_ID3, ($urandom << 16) | id3);
    write_reg(REG_SUB_COUNT, ($urandom << 3) | count);
  endtask

  // Hold until every frame is taken and every chunk has come out
  task automatic wait_idle();
    while (frames_pending != 0 || chunk_expect_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic frame_t make_frame(input logic [15:0] mid, input int len_field,
                                        input logic [63:0] body, input bit sof,
                                        input bit eof, input bit tog);
    frame_t f;
    int     eff;
    f.can_id = 29'($urandom);
    f.can_id[23:8] = mid;
    f.frame_len = 4'(len_field);
    f.frame_data = body;
    f.drain_first = 1'b0;
    eff = (len_field > 8) ? 8 : len_field;
    if (eff > 0) begin
      f.frame_data[8*eff-1] = sof;
      f.frame_data[8*eff-2] = eof;
      f.frame_data[8*eff-3] = tog;
    end
    return f;
  endfunction

  function automatic logic [63:0] rand_body();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
  endfunction

  function automatic logic [15:0] pick_mid();
    logic [15:0] m;
    if ($urandom_range(0, 99) < 85) m = cfg_id[$urandom_range(0, SLOTS - 1)];
    else m = 16'($urandom);
    return m;
  endfunction

  task automatic push_frame(input frame_t f);
    frame_q.push_back(f);
    frames_pending++;
  endtask

  task automatic stage(input frame_t f, input int lane);
    if (lane == 0) staged_a.push_back(f);
    else staged_b.push_back(f);
  endtask

  // Build a well-formed multi-frame transfer, now and then with a lost or
  // repeated frame
  task automatic stage_transfer(input logic [15:0] mid, input int lane);
    int     nframes;
    int     i;
    int     len;
    bit     long_xfer;
    bit     tog;
    frame_t f;
    long_xfer = ($urandom_range(0, 11) == 0);
    nframes = long_xfer ? $urandom_range(10, 12) : $urandom_range(2, 5);
    tog = 0;
    for (i = 0; i < nframes; i++) begin
      len = (long_xfer && $urandom_range(0, 3) != 0) ? 8 : pick_len();
      f = make_frame(mid, len, rand_body(), i == 0, i == nframes - 1, tog);
      if ($urandom_range(0, 39) != 0) stage(f, lane);
      if ($urandom_range(0, 19) == 0) stage(f, lane);
      tog = !tog;
    end
  endtask

  task automatic run_random(input int target);
    int     counted;
    int     pick;
    bit     first;
    frame_t f;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        stage_transfer(pick_mid(), 0);
        if ($urandom_range(0, 2) == 0) stage_transfer(pick_mid(), 1);
        first = ($urandom_range(0, 14) == 0);
        // interleave the two transfers frame by frame
        while (staged_a.size() != 0 || staged_b.size() != 0) begin
          if (staged_b.size() == 0 || (staged_a.size() != 0 && $urandom_range(0, 1) == 0))
            f = staged_a.pop_front();
          else
            f = staged_b.pop_front();
          f.drain_first = first;
          first = 0;
          push_frame(f);
          counted++;
        end
      end else if (pick < 75) begin
        push_frame(make_frame(pick_mid(), pick_len(), rand_body(), 1, 1, 0));
        counted++;
      end else begin
        f = make_frame(pick_mid(), $urandom_range(0, 15), rand_body(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0) f.can_id = 29'($urandom);
        push_frame(f);
        counted++;
      end
    end
  endtask

  task automatic run_directed();
    frame_t f;
    int     i;
    // empty frame
    push_frame(make_frame(16'h0000, 0, rand_body(), 1, 1, 0));
    // empty single-frame message, identifier all ones
    f = make_frame(16'hFFFF, 1, rand_body(), 1, 1, 0);
    f.can_id = '1;
    push_frame(f);
    // oversized length, identifier all zeros
    f = make_frame(16'h0000, 15, '1, 1, 1, 0);
    f.can_id = '0;
    push_frame(f);
    // toggle set on an idle slot
    push_frame(make_frame(16'h0000, 8, '1, 1, 1, 1));
    // nobody subscribed
    push_frame(make_frame(16'h5555, 8, rand_body(), 1, 1, 0));
    // continuation without a start
    push_frame(make_frame(16'h0000, 4, rand_body(), 0, 0, 0));
    // start frame too short to carry payload
    push_frame(make_frame(16'h8001, 2, rand_body(), 1, 0, 0));
    push_frame(make_frame(16'h8001, 4, rand_body(), 0, 1, 1));
    // second start in the middle of an assembly
    push_frame(make_frame(16'h7FFE, 8, rand_body(), 1, 0, 0));
    push_frame(make_frame(16'h7FFE, 8, rand_body(), 1, 0, 1));
    push_frame(make_frame(16'h7FFE, 8, rand_body(), 0, 0, 1));
    push_frame(make_frame(16'h7FFE, 8, rand_body(), 0, 1, 0));
    // single frame aborts an open assembly; the stale end is dropped
    push_frame(make_frame(16'hFFFF, 6, rand_body(), 1, 0, 0));
    push_frame(make_frame(16'hFFFF, 5, rand_body(), 1, 1, 0));
    push_frame(make_frame(16'hFFFF, 8, rand_body(), 0, 1, 1));
    // run past capacity, sent only once everything before has drained
    f = make_frame(16'h0000, 8, rand_body(), 1, 0, 0);
    f.drain_first = 1'b1;
    push_frame(f);
    for (i = 1; i <= 8; i++)
      push_frame(make_frame(16'h0000, 8, rand_body(), 0, 0, i % 2));
    push_frame(make_frame(16'h0000, 8, rand_body(), 0, 1, 1));
  endtask

  initial begin
    logic [15:0] shared_id;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // nothing subscribed
    write_reg(REG_SUB_COUNT, 32'd0);
    push_frame(make_frame(16'h0000, 8, rand_body(), 1, 1, 0));
    push_frame(make_frame(16'h0000, 3, rand_body(), 1, 0, 0));
    wait_idle();

    set_subscriptions(3'd4, 16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE);
    run_directed();
    run_random(40);
    wait_idle();

    // count above the slot count, two slots watching the same id
    shared_id = 16'($urandom);
    set_subscriptions(3'd7, shared_id, shared_id, 16'($urandom), 16'($urandom));
    run_random(35);
    wait_idle();

    set_subscriptions(3'd1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(25);
    wait_idle();

    set_subscriptions(3'd2, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(25);
    wait_idle();

    $display("Sent %0d frames over five subscription settings; checked %0d chunks",
             frames_accepted, chunks_checked);
    $display("in %0d messages, %0d of them past capacity", messages_seen, overflow_messages);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d chunk errors", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d frames and %0d chunks still outstanding",
             frames_pending, chunk_expect_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
rtl/ctr_pkg.sv
rtl/can_transfer_reassembler.sv
verif/can_transfer_reassembler_test.sv
